[sv/aes_ofb_pkg.sv]
`default_nettype none
package aes_ofb_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ROUND_W    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture data, reload/start state with initial key add
        logic restart;   // take feedback from iv on load
        logic round;     // run one round
        logic last;      // round without mix columns
        logic finish;    // form result and update feedback
    } aes_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/aes_ofb_if.sv]
`default_nettype none
interface aes_ofb_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        restart;
    modport source (output valid, data_high, data_low, restart, input ready);
    modport sink   (input valid, data_high, data_low, restart, output ready);
endinterface

interface aes_ofb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

[sv/aes_ofb_ctrl.sv]
`default_nettype none
module aes_ofb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_restart,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output aes_ofb_pkg::aes_cmd_t      cmd,
    output logic [aes_ofb_pkg::ROUND_W-1:0] rnd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [aes_ofb_pkg::ROUND_W-1:0] rnd_reg, rnd_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    // a new transaction may enter once the previous result slot will be free
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign rnd       = rnd_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.restart  = in_restart;
        cmd.round    = (state_reg == ST_RUN);
        cmd.last     = (rnd_reg == 4'(aes_ofb_pkg::NUM_ROUNDS));
        cmd.finish   = (state_reg == ST_FIN);
    end

    // sequencer: load, ten rounds, finish
    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    rnd_next   = 4'd1;
                end
            end
            ST_RUN:
            begin
                if (rnd_reg == 4'(aes_ofb_pkg::NUM_ROUNDS))
                    state_next = ST_FIN;
                else
                    rnd_next = rnd_reg + 4'd1;
            end
            ST_FIN:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

[sv/aes_ofb_dp.sv]
`default_nettype none
module aes_ofb_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire aes_ofb_pkg::aes_cmd_t cmd,
    input  wire logic [aes_ofb_pkg::ROUND_W-1:0] rnd,
    input  wire logic [127:0]          key,
    input  wire logic [127:0]          iv,
    input  wire logic [127:0]          data,
    output logic [127:0]               result
);
    logic [127:0] fb_reg, fb_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [127:0] data_reg;
    logic [127:0] res_reg;
    logic [127:0] src;
    logic [7:0]   sb [16];
    logic [7:0]   kb [16];
    logic [7:0]   nk [16];
    logic [7:0]   ss [16];
    logic [7:0]   mc [16];
    logic [7:0]   t  [4];

    // byte i sits at bits 127-8i
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = st_reg[127-8*i -: 8];
            kb[i] = rk_reg[127-8*i -: 8];
        end
    end

    // key schedule step
    always_comb
    begin
        t[0] = aes_ofb_pkg::sbox(kb[13]) ^ aes_ofb_pkg::rcon(rnd);
        t[1] = aes_ofb_pkg::sbox(kb[14]);
        t[2] = aes_ofb_pkg::sbox(kb[15]);
        t[3] = aes_ofb_pkg::sbox(kb[12]);
        for (int i = 0; i < 4; i++)
            nk[i] = kb[i] ^ t[i];
        for (int i = 4; i < 16; i++)
            nk[i] = kb[i] ^ nk[i-4];
    end

    // sub bytes, shift rows, mix columns
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                ss[4*c+r] = aes_ofb_pkg::sbox(sb[4*((c+r)%4)+r]);
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                logic [7:0] a, b, all, x;
                a   = ss[4*c+r];
                b   = ss[4*c+((r+1)%4)];
                all = ss[4*c] ^ ss[4*c+1] ^ ss[4*c+2] ^ ss[4*c+3];
                x   = {a[6:0] ^ b[6:0], 1'b0} ^ (((a[7] ^ b[7])) ? 8'h1b : 8'h00);
                mc[4*c+r] = a ^ all ^ x;
            end
        end
    end

    assign src = cmd.restart ? iv : fb_reg;

    always_comb
    begin
        fb_next = fb_reg;
        st_next = st_reg;
        rk_next = rk_reg;
        if (cmd.load)
        begin
            fb_next = src;
            st_next = src ^ key;
            rk_next = key;
        end
        else if (cmd.round)
        begin
            rk_next = '0;
            for (int i = 0; i < 16; i++)
            begin
                rk_next[127-8*i -: 8] = nk[i];
                st_next[127-8*i -: 8] = (cmd.last ? ss[i] : mc[i]) ^ nk[i];
            end
        end
        else if (cmd.finish)
            fb_next = st_reg;
    end

    // state registers cleared to match the zero iv at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
            st_reg <= '0;
            rk_reg <= '0;
        end
        else
        begin
            fb_reg <= fb_next;
            st_reg <= st_next;
            rk_reg <= rk_next;
        end
    end

    // payload capture and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            data_reg <= data;
        if (cmd.finish)
            res_reg <= data_reg ^ st_reg;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

[sv/aes128_ofb_keystream_cipher.sv]
`default_nettype none
// AES-128 OFB keystream cipher. Each input transaction carries a 128-bit block
// (data_high holds bytes 0..7, big-endian) that comes back XORed with the next
// keystream block; encryption and decryption are the same. Setting restart
// reloads the feedback register from the IV before the block. On acceptance the
// state is loaded with the initial key addition, then the rounds run through a
// single round unit with on-the-fly key expansion, and the finish step registers
// the result. The next block is accepted only once the controller is idle again
// and the result slot is free, so no block is taken while the last one is still
// in flight, and none while its result waits untaken. Configure key and IV only
// while idle; a new key applies to the next block, a new IV only at the next
// restart.
module aes128_ofb_keystream_cipher (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [aes_ofb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aes_ofb_pkg::CFG_DATA_W-1:0]  cfg_data,
    aes_ofb_in_if.sink                                in_ch,
    aes_ofb_out_if.source                             out_ch
);
    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    aes_ofb_pkg::aes_cmd_t cmd;
    logic [aes_ofb_pkg::ROUND_W-1:0] rnd;
    logic [127:0] result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aes_ofb_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_ofb_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aes_ofb_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                aes_ofb_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_ofb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_restart (in_ch.restart),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .cmd        (cmd),
        .rnd        (rnd)
    );

    aes_ofb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .rnd    (rnd),
        .key    ({key_high_reg, key_low_reg}),
        .iv     ({iv_high_reg, iv_low_reg}),
        .data   ({in_ch.data_high, in_ch.data_low}),
        .result (result)
    );

    assign out_ch.result_high = result[127:64];
    assign out_ch.result_low  = result[63:0];

    // no new block while a result waits untaken
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("accepted block while result stalled");

    // a finish always raises out valid next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_ch.valid)
        else $error("result not presented after finish");

    // neither rounds nor a finish ever run at the same time as a load
    a_load_round: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && (cmd.round || cmd.finish)))
        else $error("load overlaps running block");
endmodule
`default_nettype wire

[sim/aes128_ofb_keystream_cipher_test.sv]
`default_nettype none
module aes128_ofb_keystream_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 750;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        restart;
    } block_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } block_out_t;

    // directed row: stimulus plus optional typed-in answer
    typedef struct {
        block_in_t  blk;
        bit         has_answer;
        block_out_t answer;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    aes_ofb_in_if  in_ch();
    aes_ofb_out_if out_ch();

    aes128_ofb_keystream_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor state
    logic [127:0] cipher_key;
    logic [127:0] iv_block;
    logic [127:0] chain_block;

    block_out_t pending_blocks[$];
    int  errors;
    int  accepted_in;
    int  accepted_out;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  restart_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one aes-128 block encryption, byte 0 in bits 127:120
    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt,
                                                 input logic [127:0] key);
        logic [7:0] s[16];
        logic [7:0] k[16];
        logic [7:0] o[16];
        logic [7:0] t[4];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
            k[i] = key[127-8*i -: 8];
        end
        for (int rnd = 1; rnd <= aes_ofb_pkg::NUM_ROUNDS; rnd++)
        begin
            // key schedule step
            t[0] = aes_ofb_pkg::sbox(k[13]) ^ aes_ofb_pkg::rcon(rnd[3:0]);
            t[1] = aes_ofb_pkg::sbox(k[14]);
            t[2] = aes_ofb_pkg::sbox(k[15]);
            t[3] = aes_ofb_pkg::sbox(k[12]);
            for (int i = 0; i < 4; i++)
                k[i] = k[i] ^ t[i];
            for (int i = 4; i < 16; i++)
                k[i] = k[i] ^ k[i-4];
            // subbytes and shiftrows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    o[4*c+r] = aes_ofb_pkg::sbox(s[4*((c+r)%4)+r]);
            // mixcolumns except in the last round
            if (rnd != aes_ofb_pkg::NUM_ROUNDS)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    o[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    o[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    o[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    o[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = o[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // advance the keystream and return the expected output block
    function automatic block_out_t ofb_next(input block_in_t b);
        logic [127:0] ks;
        if (b.restart)
            chain_block = iv_block;
        ks = aes_encrypt(chain_block, cipher_key);
        chain_block = ks;
        return {b.data_high ^ ks[127:64], b.data_low ^ ks[63:0]};
    endfunction

    // one register write, with the write enable dropped again before the task returns
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            aes_ofb_pkg::REG_KEY_HIGH: cipher_key[127:64] = val;
            aes_ofb_pkg::REG_KEY_LOW:  cipher_key[63:0]   = val;
            aes_ofb_pkg::REG_IV_HIGH:  iv_block[127:64]   = val;
            aes_ofb_pkg::REG_IV_LOW:   iv_block[63:0]     = val;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // send one block, idling at random beforehand
    task automatic send_block(input block_in_t b, input bit has_answer,
                              input block_out_t answer);
        block_out_t exp_blk;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.data_high <= b.data_high;
        in_ch.data_low  <= b.data_low;
        in_ch.restart   <= b.restart;
        // ready is stable between edges, so look at it mid-cycle
        @(negedge clk);
        while (!in_ch.ready)
            @(negedge clk);
        @(posedge clk);
        exp_blk = ofb_next(b);
        if (has_answer && exp_blk != answer)
        begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, answer, exp_blk);
            errors++;
        end
        pending_blocks.insert(pending_blocks.size(), exp_blk);
        accepted_in++;
        if (b.restart)
            restart_count++;
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic block_in_t random_block();
        block_in_t b;
        b.data_high = {$urandom, $urandom};
        b.data_low  = {$urandom, $urandom};
        b.restart   = ($urandom_range(15) == 0);
        return b;
    endfunction

    // result checking, mid-cycle: a transaction seen here completes at the next edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                accepted_out++;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h_%h",
                             $time, out_ch.result_high, out_ch.result_low);
                    errors++;
                end
                else
                begin
                    block_out_t exp_blk;
                    exp_blk = pending_blocks.pop_front();
                    if (out_ch.result_high !== exp_blk.result_high)
                    begin
                        $display("%0t result_high mismatch: expected %h actual %h",
                                 $time, exp_blk.result_high, out_ch.result_high);
                        errors++;
                    end
                    if (out_ch.result_low !== exp_blk.result_low)
                    begin
                        $display("%0t result_low mismatch: expected %h actual %h",
                                 $time, exp_blk.result_low, out_ch.result_low);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no transaction
    always @(negedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending_blocks.size());
            $display("** aes128_ofb_keystream_cipher: FAILED **");
            $finish;
        end
    end

    directed_row_t directed_rows[$];

    initial
    begin
        block_out_t none;
        directed_row_t row;
        none = '0;
        errors = 0; accepted_in = 0; accepted_out = 0; idle_cycles = 0;
        restart_count = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        cipher_key = '0; iv_block = '0; chain_block = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = aes_ofb_pkg::REG_KEY_HIGH; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.data_high = '0; in_ch.data_low = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero key and zero iv: first keystream block is aes(0, 0)
        row.blk = {64'h0, 64'h0, 1'b0};
        row.has_answer = 1'b1;
        row.answer = {64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
        directed_rows.insert(directed_rows.size(), row);
        row.blk = {64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0};
        row.has_answer = 1'b0; row.answer = none;
        directed_rows.insert(directed_rows.size(), row);
        // restart back to the zero iv gives the same first block again
        row.blk = {64'h0, 64'h0, 1'b1};
        row.has_answer = 1'b1;
        row.answer = {64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e};
        directed_rows.insert(directed_rows.size(), row);
        row.blk = {64'h8000000000000000, 64'h0000000000000001, 1'b0};
        row.has_answer = 1'b0; row.answer = none;
        directed_rows.insert(directed_rows.size(), row);
        foreach (directed_rows[i])
            send_block(directed_rows[i].blk, directed_rows[i].has_answer,
                       directed_rows[i].answer);
        wait_drained();

        // standard test vector key, all-ones iv, iv written without restart
        write_reg(aes_ofb_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_reg(aes_ofb_pkg::REG_KEY_LOW,  64'habf7158809cf4f3c);
        write_reg(aes_ofb_pkg::REG_IV_HIGH,  64'hffffffffffffffff);
        write_reg(aes_ofb_pkg::REG_IV_LOW,   64'hffffffffffffffff);
        send_block({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0}, 1'b0, none);
        send_block({64'h0, 64'h0, 1'b1}, 1'b0, none);
        send_block({64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0}, 1'b0, none);
        wait_drained();
        // key change mid-stream: first block without reload, then one with restart
        write_reg(aes_ofb_pkg::REG_KEY_HIGH, 64'hffffffffffffffff);
        write_reg(aes_ofb_pkg::REG_KEY_LOW,  64'hffffffffffffffff);
        send_block({64'h0, 64'hffffffffffffffff, 1'b0}, 1'b0, none);
        send_block({64'hffffffffffffffff, 64'h0, 1'b1}, 1'b0, none);
        wait_drained();

        // random phases with different idling and settings
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 17 : 0;
            write_reg(aes_ofb_pkg::REG_KEY_HIGH, {$urandom, $urandom});
            write_reg(aes_ofb_pkg::REG_KEY_LOW,  {$urandom, $urandom});
            write_reg(aes_ofb_pkg::REG_IV_HIGH,
                      (phase == 2) ? 64'h0 : {$urandom, $urandom});
            write_reg(aes_ofb_pkg::REG_IV_LOW,
                      (phase == 2) ? 64'h0 : {$urandom, $urandom});
            send_block({64'h0, 64'h0, 1'b1}, 1'b0, none);
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                // once per phase, hold off until the pipeline is empty
                if (n == 100)
                    while (pending_blocks.size() != 0)
                        @(posedge clk);
                send_block(random_block(), 1'b0, none);
            end
            wait_drained();
        end

        $display("covered %0d blocks (%0d with restart) over several keys and ivs",
                 accepted_in, restart_count);
        $display("results checked: %0d, errors: %0d", accepted_out, errors);
        if (errors == 0 && pending_blocks.size() == 0)
            $display("** aes128_ofb_keystream_cipher: PASSED **");
        else
            $display("** aes128_ofb_keystream_cipher: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
sv/aes_ofb_pkg.sv
sv/aes_ofb_if.sv
sv/aes_ofb_ctrl.sv
sv/aes_ofb_dp.sv
sv/aes128_ofb_keystream_cipher.sv
sim/aes128_ofb_keystream_cipher_test.sv
